### src/bwgp_pkg.sv
`timescale 1ns / 1ps

package bwgp_pkg;

  // Field and register widths
  localparam int IDX_W     = 5;
  localparam int COORD_W   = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  // Mesh size limit and reset value of grid_res
  localparam int unsigned   MAX_GRID_RES = 16;
  localparam logic [IDX_W-1:0] GRID_RESET = 5'd10;

  // Q1.16 fractions, 0.0 .. 1.0 inclusive
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  // Reciprocal table: floor(2^RECIP_SHIFT / g)
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int NUM_W       = IDX_W + FRAC_BITS + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_RES = 3'd0,
    CFG_CORNER_A = 3'd1,
    CFG_CORNER_B = 3'd2,
    CFG_HANDLE_A = 3'd3,
    CFG_HANDLE_B = 3'd4,
    CFG_HANDLE_C = 3'd5,
    CFG_HANDLE_D = 3'd6
  } cfg_reg_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [IDX_W-1:0] g);
    logic [RECIP_W-1:0] r;
    unique case (g)
      5'd2:    r = 25'd8388608;
      5'd3:    r = 25'd5592405;
      5'd4:    r = 25'd4194304;
      5'd5:    r = 25'd3355443;
      5'd6:    r = 25'd2796202;
      5'd7:    r = 25'd2396745;
      5'd8:    r = 25'd2097152;
      5'd9:    r = 25'd1864135;
      5'd10:   r = 25'd1677721;
      5'd11:   r = 25'd1525201;
      5'd12:   r = 25'd1398101;
      5'd13:   r = 25'd1290555;
      5'd14:   r = 25'd1198372;
      5'd15:   r = 25'd1118481;
      5'd16:   r = 25'd1048576;
      5'd17:   r = 25'd986895;
      5'd18:   r = 25'd932067;
      5'd19:   r = 25'd883011;
      5'd20:   r = 25'd838860;
      5'd21:   r = 25'd798915;
      5'd22:   r = 25'd762600;
      5'd23:   r = 25'd729444;
      5'd24:   r = 25'd699050;
      5'd25:   r = 25'd671088;
      5'd26:   r = 25'd645277;
      5'd27:   r = 25'd621378;
      5'd28:   r = 25'd599186;
      5'd29:   r = 25'd578524;
      5'd30:   r = 25'd559240;
      5'd31:   r = 25'd541200;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

  // Estimate of floor(idx * 2^16 / g); low by at most one
  function automatic logic [FRAC_W-1:0] frac_est(input logic [IDX_W-1:0] idx,
                                                 input logic [IDX_W-1:0] g);
    logic [IDX_W+RECIP_W-1:0] p;
    p = (IDX_W+RECIP_W)'(idx) * (IDX_W+RECIP_W)'(recip(g));
    return p[RECIP_SHIFT-FRAC_BITS +: FRAC_W];
  endfunction

  // One remainder check lifts the estimate to the exact quotient
  function automatic logic [FRAC_W-1:0] frac_fix(input logic [IDX_W-1:0]  idx,
                                                 input logic [IDX_W-1:0]  g,
                                                 input logic [FRAC_W-1:0] q);
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] rem;
    num = NUM_W'({idx, {FRAC_BITS{1'b0}}});
    rem = num - NUM_W'(q) * NUM_W'(g);
    if (rem >= NUM_W'(g)) begin
      return q + 1'b1;
    end
    return q;
  endfunction

endpackage

### src/bezier_warp_grid_point_unit.sv
`timescale 1ns / 1ps

// Bezier warp mesh vertex generator. Give a column and row index with start and the
// warped x/y position (signed Q12.4) comes out on x_coord_o/y_coord_o with done_o, for
// exactly one cycle; the receiver cannot stall it. One vertex per clock is sustained:
// the datapath is a ten-stage pipeline with no feedback, so busy stays low and start
// may be held high every cycle. The latency is set by the chain of dependent
// multiplies (fraction, t^2, t^3, edge terms, final cubic terms), each with a register
// after it. Indices above grid_res clamp to grid_res; grid_res of zero acts as one and
// values above 16 act as 16. saturated_o flags a result clamped to the 16-bit range.
// Configuration writes are taken at any time (cfg_ready_o stays high) but must only
// happen while no vertex is in flight.

module bezier_warp_grid_point_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [bwgp_pkg::IDX_W-1:0]        col_index_i,
  input  logic [bwgp_pkg::IDX_W-1:0]        row_index_i,
  output logic                              done_o,
  output logic signed [bwgp_pkg::COORD_W-1:0] x_coord_o,
  output logic signed [bwgp_pkg::COORD_W-1:0] y_coord_o,
  output logic                              saturated_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bwgp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bwgp_pkg::CFG_W-1:0]        cfg_data_i
);
  import bwgp_pkg::*;

  localparam int NSTAGE = 10;
  // edge curve coefficient, product and value widths
  localparam int EC_W = 22;
  localparam int EP_W = EC_W + FRAC_W + 1;
  localparam int EV_W = 26;
  // inner handle blend
  localparam int BD_W = COORD_W + 1;
  localparam int BP_W = BD_W + FRAC_W + 1;
  localparam int IN_W = COORD_W + 3;
  // final cubic
  localparam int SC_W = 32;
  localparam int SP_W = SC_W + FRAC_W + 1;
  localparam int SS_W = 40;

  localparam logic signed [SS_W-1:0] SAT_MAX = 40'sd32767;
  localparam logic signed [SS_W-1:0] SAT_MIN = -40'sd32768;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] grid_res_q;
  logic [CFG_W-1:0] corner_q [2];
  logic [CFG_W-1:0] handle_q [4];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_res_q <= GRID_RESET;
      for (int i = 0; i < 2; i++) corner_q[i] <= '0;
      for (int i = 0; i < 4; i++) handle_q[i] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_GRID_RES: grid_res_q  <= cfg_data_i[IDX_W-1:0];
        CFG_CORNER_A: corner_q[0] <= cfg_data_i;
        CFG_CORNER_B: corner_q[1] <= cfg_data_i;
        CFG_HANDLE_A: handle_q[0] <= cfg_data_i;
        CFG_HANDLE_B: handle_q[1] <= cfg_data_i;
        CFG_HANDLE_C: handle_q[2] <= cfg_data_i;
        CFG_HANDLE_D: handle_q[3] <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Unpack points: [point][axis], axis 0 = x, 1 = y
  coord_t cor [4][2];
  coord_t hnd [8][2];
  // edge curve control points [edge][axis][point], edge 0 = left, 1 = right
  coord_t ep  [2][2][4];
  // inner handle blend ends [axis][inner]
  coord_t ihi [2][2];
  coord_t ilo [2][2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 4; k++) begin
        cor[k][a] = corner_q[k >> 1][(k & 1) * 32 + a * 16 +: COORD_W];
      end
      for (int k = 0; k < 8; k++) begin
        hnd[k][a] = handle_q[k >> 1][(k & 1) * 32 + a * 16 +: COORD_W];
      end
      ep[0][a][0] = cor[0][a];
      ep[0][a][1] = hnd[0][a];
      ep[0][a][2] = hnd[7][a];
      ep[0][a][3] = cor[3][a];
      ep[1][a][0] = cor[1][a];
      ep[1][a][1] = hnd[3][a];
      ep[1][a][2] = hnd[4][a];
      ep[1][a][3] = cor[2][a];
      ihi[a][0]   = hnd[1][a];
      ilo[a][0]   = hnd[6][a];
      ihi[a][1]   = hnd[2][a];
      ilo[a][1]   = hnd[5][a];
    end
  end

  // Power-basis coefficients of the edge curves. They are registered copies that follow
  // the configuration registers in the next cycle and are first read in stage 4.
  logic signed [EC_W-1:0] ec_a_d [2][2], ec_a_q [2][2];
  logic signed [EC_W-1:0] ec_b_d [2][2], ec_b_q [2][2];
  logic signed [EC_W-1:0] ec_c_d [2][2], ec_c_q [2][2];

  always_comb begin
    logic signed [EC_W-1:0] w0, w1, w2, w3, d10, d21, d2;
    for (int e = 0; e < 2; e++) begin
      for (int a = 0; a < 2; a++) begin
        w0  = EC_W'(ep[e][a][0]);
        w1  = EC_W'(ep[e][a][1]);
        w2  = EC_W'(ep[e][a][2]);
        w3  = EC_W'(ep[e][a][3]);
        d10 = w1 - w0;
        d21 = w2 - w1;
        d2  = d21 - d10;
        ec_c_d[e][a] = d10 + (d10 <<< 1);
        ec_b_d[e][a] = d2 + (d2 <<< 1);
        ec_a_d[e][a] = (w3 - w0) - (d21 + (d21 <<< 1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ec_a_q <= ec_a_d;
    ec_b_q <= ec_b_d;
    ec_c_q <= ec_c_d;
  end

  // ---------------------------------------------------------------------------
  // Pipeline valid bits; no backpressure, so every stage advances each cycle
  // ---------------------------------------------------------------------------
  logic [NSTAGE-1:0] vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTAGE-2:0], start && !busy};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: clamp, reciprocal estimate of index / grid_res
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]  g_eff;
  logic [IDX_W-1:0]  col_c, row_c;
  logic [IDX_W-1:0]  g1_q, col1_q, row1_q;
  logic [FRAC_W-1:0] qu1_d, qs1_d, qu1_q, qs1_q;

  always_comb begin
    if (grid_res_q == '0) begin
      g_eff = IDX_W'(1);
    end else if (grid_res_q > IDX_W'(MAX_GRID_RES)) begin
      g_eff = IDX_W'(MAX_GRID_RES);
    end else begin
      g_eff = grid_res_q;
    end
    col_c = (col_index_i > g_eff) ? g_eff : col_index_i;
    row_c = (row_index_i > g_eff) ? g_eff : row_index_i;
    qu1_d = frac_est(col_c, g_eff);
    qs1_d = frac_est(row_c, g_eff);
  end

  always_ff @(posedge clk_i) begin
    g1_q   <= g_eff;
    col1_q <= col_c;
    row1_q <= row_c;
    qu1_q  <= qu1_d;
    qs1_q  <= qs1_d;
  end

  // Stage 2: exact fractions u = col/g, s = row/g
  logic [FRAC_W-1:0] u2_q, s2_q;

  always_ff @(posedge clk_i) begin
    u2_q <= frac_fix(col1_q, g1_q, qu1_q);
    s2_q <= frac_fix(row1_q, g1_q, qs1_q);
  end

  // Stage 3: squares, inner handle blend products
  logic [2*FRAC_W-1:0]    sq_s, sq_u;
  logic [FRAC_W-1:0]      t2s3_q, t2u3_q, s3_q, u3_q;
  logic signed [BP_W-1:0] bp3_d [2][2], bp3_q [2][2];

  always_comb begin
    logic signed [BP_W-1:0] diff, wgt;
    sq_s = (2*FRAC_W)'(s2_q) * (2*FRAC_W)'(s2_q);
    sq_u = (2*FRAC_W)'(u2_q) * (2*FRAC_W)'(u2_q);
    wgt  = BP_W'(FRAC_ONE - s2_q);  // 1 - s, non-negative
    for (int a = 0; a < 2; a++) begin
      for (int i = 0; i < 2; i++) begin
        diff = BP_W'(BD_W'(ihi[a][i]) - BD_W'(ilo[a][i]));
        bp3_d[a][i] = diff * wgt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t2s3_q <= sq_s[FRAC_BITS +: FRAC_W];
    t2u3_q <= sq_u[FRAC_BITS +: FRAC_W];
    s3_q   <= s2_q;
    u3_q   <= u2_q;
    bp3_q  <= bp3_d;
  end

  // Stage 4: cubes, edge b and c terms, blend result
  logic [2*FRAC_W-1:0]    cu_s, cu_u;
  logic [FRAC_W-1:0]      t3s4_q, t3u4_q, t2u4_q, u4_q;
  logic signed [EP_W-1:0] pb4_d [2][2], pb4_q [2][2];
  logic signed [EP_W-1:0] pc4_d [2][2], pc4_q [2][2];
  logic signed [IN_W-1:0] in4_d [2][2], in4_q [2][2];

  always_comb begin
    logic signed [FRAC_W:0] t2_sg, s_sg;
    cu_s  = (2*FRAC_W)'(t2s3_q) * (2*FRAC_W)'(s3_q);
    cu_u  = (2*FRAC_W)'(t2u3_q) * (2*FRAC_W)'(u3_q);
    t2_sg = $signed({1'b0, t2s3_q});
    s_sg  = $signed({1'b0, s3_q});
    for (int e = 0; e < 2; e++) begin
      for (int a = 0; a < 2; a++) begin
        pb4_d[e][a] = EP_W'(ec_b_q[e][a]) * EP_W'(t2_sg);
        pc4_d[e][a] = EP_W'(ec_c_q[e][a]) * EP_W'(s_sg);
      end
    end
    for (int a = 0; a < 2; a++) begin
      for (int i = 0; i < 2; i++) begin
        in4_d[a][i] = IN_W'(ilo[a][i]) + IN_W'(bp3_q[a][i] >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t3s4_q <= cu_s[FRAC_BITS +: FRAC_W];
    t3u4_q <= cu_u[FRAC_BITS +: FRAC_W];
    t2u4_q <= t2u3_q;
    u4_q   <= u3_q;
    pb4_q  <= pb4_d;
    pc4_q  <= pc4_d;
    in4_q  <= in4_d;
  end

  // Stage 5: edge a terms
  logic signed [EP_W-1:0] pa5_d [2][2], pa5_q [2][2];
  logic signed [EP_W-1:0] pb5_q [2][2], pc5_q [2][2];
  logic signed [IN_W-1:0] in5_q [2][2];
  logic [FRAC_W-1:0]      t3u5_q, t2u5_q, u5_q;

  always_comb begin
    logic signed [FRAC_W:0] t3_sg;
    t3_sg = $signed({1'b0, t3s4_q});
    for (int e = 0; e < 2; e++) begin
      for (int a = 0; a < 2; a++) begin
        pa5_d[e][a] = EP_W'(ec_a_q[e][a]) * EP_W'(t3_sg);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pa5_q  <= pa5_d;
    pb5_q  <= pb4_q;
    pc5_q  <= pc4_q;
    in5_q  <= in4_q;
    t3u5_q <= t3u4_q;
    t2u5_q <= t2u4_q;
    u5_q   <= u4_q;
  end

  // Stage 6: left and right edge points at s
  logic signed [EV_W-1:0] edge6_d [2][2], edge6_q [2][2];
  logic signed [IN_W-1:0] in6_q [2][2];
  logic [FRAC_W-1:0]      t3u6_q, t2u6_q, u6_q;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int a = 0; a < 2; a++) begin
        edge6_d[e][a] = EV_W'(pa5_q[e][a] >>> FRAC_BITS)
                      + EV_W'(pb5_q[e][a] >>> FRAC_BITS)
                      + EV_W'(pc5_q[e][a] >>> FRAC_BITS)
                      + EV_W'(ep[e][a][0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    edge6_q <= edge6_d;
    in6_q   <= in5_q;
    t3u6_q  <= t3u5_q;
    t2u6_q  <= t2u5_q;
    u6_q    <= u5_q;
  end

  // Stage 7: coefficients of the cross curve left - in0 - in1 - right
  logic signed [SC_W-1:0] a7_d [2], a7_q [2];
  logic signed [SC_W-1:0] b7_d [2], b7_q [2];
  logic signed [SC_W-1:0] c7_d [2], c7_q [2];
  logic signed [EV_W-1:0] p07_q [2];
  logic [FRAC_W-1:0]      t3u7_q, t2u7_q, u7_q;

  always_comb begin
    logic signed [SC_W-1:0] w0, w1, w2, w3, d10, d21, d2;
    for (int a = 0; a < 2; a++) begin
      w0  = SC_W'(edge6_q[0][a]);
      w1  = SC_W'(in6_q[a][0]);
      w2  = SC_W'(in6_q[a][1]);
      w3  = SC_W'(edge6_q[1][a]);
      d10 = w1 - w0;
      d21 = w2 - w1;
      d2  = d21 - d10;
      c7_d[a] = d10 + (d10 <<< 1);
      b7_d[a] = d2 + (d2 <<< 1);
      a7_d[a] = (w3 - w0) - (d21 + (d21 <<< 1));
    end
  end

  always_ff @(posedge clk_i) begin
    a7_q   <= a7_d;
    b7_q   <= b7_d;
    c7_q   <= c7_d;
    for (int a = 0; a < 2; a++) p07_q[a] <= edge6_q[0][a];
    t3u7_q <= t3u6_q;
    t2u7_q <= t2u6_q;
    u7_q   <= u6_q;
  end

  // Stage 8: cross curve terms at u
  logic signed [SP_W-1:0] pa8_d [2], pa8_q [2];
  logic signed [SP_W-1:0] pb8_d [2], pb8_q [2];
  logic signed [SP_W-1:0] pc8_d [2], pc8_q [2];
  logic signed [EV_W-1:0] p08_q [2];

  always_comb begin
    logic signed [FRAC_W:0] t3_sg, t2_sg, u_sg;
    t3_sg = $signed({1'b0, t3u7_q});
    t2_sg = $signed({1'b0, t2u7_q});
    u_sg  = $signed({1'b0, u7_q});
    for (int a = 0; a < 2; a++) begin
      pa8_d[a] = SP_W'(a7_q[a]) * SP_W'(t3_sg);
      pb8_d[a] = SP_W'(b7_q[a]) * SP_W'(t2_sg);
      pc8_d[a] = SP_W'(c7_q[a]) * SP_W'(u_sg);
    end
  end

  always_ff @(posedge clk_i) begin
    pa8_q <= pa8_d;
    pb8_q <= pb8_d;
    pc8_q <= pc8_d;
    p08_q <= p07_q;
  end

  // Stage 9: full-precision vertex coordinate
  logic signed [SS_W-1:0] sum9_d [2], sum9_q [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sum9_d[a] = SS_W'(pa8_q[a] >>> FRAC_BITS)
                + SS_W'(pb8_q[a] >>> FRAC_BITS)
                + SS_W'(pc8_q[a] >>> FRAC_BITS)
                + SS_W'(p08_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum9_q <= sum9_d;
  end

  // Stage 10: saturate to 16 bits, output register
  coord_t crd_d [2];
  logic   sat_d;
  coord_t x_q, y_q;
  logic   sat_q;

  always_comb begin
    sat_d = 1'b0;
    for (int a = 0; a < 2; a++) begin
      if (sum9_q[a] > SAT_MAX) begin
        crd_d[a] = COORD_W'(SAT_MAX);
        sat_d    = 1'b1;
      end else if (sum9_q[a] < SAT_MIN) begin
        crd_d[a] = COORD_W'(SAT_MIN);
        sat_d    = 1'b1;
      end else begin
        crd_d[a] = COORD_W'(sum9_q[a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= crd_d[0];
    y_q   <= crd_d[1];
    sat_q <= sat_d;
  end

  assign done_o      = vld_q[NSTAGE-1];
  assign x_coord_o   = x_q;
  assign y_coord_o   = y_q;
  assign saturated_o = sat_q;

endmodule

### sim/bwgp_vertex_checker.sv
`timescale 1ns / 1ps

// Watches the vertex and config channels, predicts each warped vertex and
// compares it with what comes out on done.
module bwgp_vertex_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic [bwgp_pkg::IDX_W-1:0]          col_index_i,
  input  logic [bwgp_pkg::IDX_W-1:0]          row_index_i,
  input  logic                                done_i,
  input  logic signed [bwgp_pkg::COORD_W-1:0] x_coord_i,
  input  logic signed [bwgp_pkg::COORD_W-1:0] y_coord_i,
  input  logic                                saturated_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [bwgp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bwgp_pkg::CFG_W-1:0]          cfg_data_i,
  output int                                  mismatch_cnt_o,
  output int                                  in_flight_o
);
  import bwgp_pkg::*;

  localparam longint FRAC_UNIT = 65536;
  localparam longint COORD_MAX = 32767;
  localparam longint COORD_MIN = -32768;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   sat;
  } vertex_t;

  logic [IDX_W-1:0] grid_cfg;
  logic [CFG_W-1:0] corner_cfg [2];
  logic [CFG_W-1:0] handle_cfg [4];

  vertex_t pending_vertices [$];
  vertex_t want;
  int      errs;

  function automatic longint corner_c(int k, int ax);
    logic [CFG_W-1:0] w;
    w = corner_cfg[k / 2];
    return longint'(coord_t'(w[16 * ((k % 2) * 2 + ax) +: 16]));
  endfunction

  function automatic longint handle_c(int k, int ax);
    logic [CFG_W-1:0] w;
    w = handle_cfg[k / 2];
    return longint'(coord_t'(w[16 * ((k % 2) * 2 + ax) +: 16]));
  endfunction

  // Power-basis cubic, each coefficient term floored back to Q12.4, powers of t to Q1.16
  function automatic longint bez_cubic(longint p0, longint p1, longint p2, longint p3,
                                       longint t);
    longint c, b, a, t2, t3;
    c  = 3 * (p1 - p0);
    b  = 3 * (p2 - p1) - c;
    a  = p3 - p0 - c - b;
    t2 = (t * t) >>> FRAC_BITS;
    t3 = (t2 * t) >>> FRAC_BITS;
    return ((a * t3) >>> FRAC_BITS) + ((b * t2) >>> FRAC_BITS) +
           ((c * t) >>> FRAC_BITS) + p0;
  endfunction

  function automatic longint blend(longint hi, longint lo, longint s);
    return lo + (((hi - lo) * (FRAC_UNIT - s)) >>> FRAC_BITS);
  endfunction

  function automatic longint axis_pos(int ax, longint s, longint u);
    longint edge_l, edge_r, in1, in2;
    edge_l = bez_cubic(corner_c(0, ax), handle_c(0, ax), handle_c(7, ax),
                       corner_c(3, ax), s);
    edge_r = bez_cubic(corner_c(1, ax), handle_c(3, ax), handle_c(4, ax),
                       corner_c(2, ax), s);
    in1    = blend(handle_c(1, ax), handle_c(6, ax), s);
    in2    = blend(handle_c(2, ax), handle_c(5, ax), s);
    return bez_cubic(edge_l, in1, in2, edge_r, u);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_MAX) begin
      return coord_t'(COORD_MAX);
    end
    if (v < COORD_MIN) begin
      return coord_t'(COORD_MIN);
    end
    return coord_t'(v);
  endfunction

  function automatic vertex_t warp_vertex(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
    longint  g, c, r, s, u, vx, vy;
    vertex_t res;
    g = grid_cfg;
    if (g == 0) begin
      g = 1;
    end
    if (g > MAX_GRID_RES) begin
      g = MAX_GRID_RES;
    end
    c = (col > g) ? g : col;
    r = (row > g) ? g : row;
    s = (r << FRAC_BITS) / g;
    u = (c << FRAC_BITS) / g;
    vx = axis_pos(0, s, u);
    vy = axis_pos(1, s, u);
    res.x   = clamp_coord(vx);
    res.y   = clamp_coord(vy);
    res.sat = (vx > COORD_MAX) || (vx < COORD_MIN) || (vy > COORD_MAX) || (vy < COORD_MIN);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cfg = GRID_RESET;
      foreach (corner_cfg[i]) corner_cfg[i] = '0;
      foreach (handle_cfg[i]) handle_cfg[i] = '0;
      pending_vertices.delete();
      errs = 0;
      mismatch_cnt_o <= 0;
      in_flight_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_GRID_RES: grid_cfg      = cfg_data_i[IDX_W-1:0];
          CFG_CORNER_A: corner_cfg[0] = cfg_data_i;
          CFG_CORNER_B: corner_cfg[1] = cfg_data_i;
          CFG_HANDLE_A: handle_cfg[0] = cfg_data_i;
          CFG_HANDLE_B: handle_cfg[1] = cfg_data_i;
          CFG_HANDLE_C: handle_cfg[2] = cfg_data_i;
          CFG_HANDLE_D: handle_cfg[3] = cfg_data_i;
          default: ;  // unused index, write dropped
        endcase
      end
      if (start_i && !busy_i) begin
        pending_vertices.push_back(warp_vertex(col_index_i, row_index_i));
      end
      if (done_i) begin
        if (pending_vertices.size() == 0) begin
          $display("%0t: vertex out with none pending, actual x %0d y %0d sat %0b",
                   $time, x_coord_i, y_coord_i, saturated_i);
          errs++;
        end else begin
          want = pending_vertices.pop_front();
          if (x_coord_i !== want.x) begin
            $display("%0t: x_coord mismatch, expected %0d, actual %0d",
                     $time, want.x, x_coord_i);
            errs++;
          end
          if (y_coord_i !== want.y) begin
            $display("%0t: y_coord mismatch, expected %0d, actual %0d",
                     $time, want.y, y_coord_i);
            errs++;
          end
          if (saturated_i !== want.sat) begin
            $display("%0t: saturated mismatch, expected %0b, actual %0b",
                     $time, want.sat, saturated_i);
            errs++;
          end
        end
      end
      mismatch_cnt_o <= errs;
      in_flight_o    <= pending_vertices.size();
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the warp mesh vertex unit. The checker beside the
// DUT does all prediction; this module only drives transfers and decides.
module tb_top;
  import bwgp_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 16;      // pipeline is ten deep
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 130;
  localparam int IDLE_PCT     = 16;      // random gaps, about 28% idle overall
  localparam int QUIET_PHASE  = 3;       // phase run with no gaps at all

  // 3-bit index space has one slot past the register list
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum int {PAT_ZERO, PAT_RANDOM, PAT_SMALL, PAT_FLOOR, PAT_CEIL, PAT_EXTREME}
    slice_pat_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [IDX_W-1:0]          col_index = '0;
  logic [IDX_W-1:0]          row_index = '0;
  logic                      done;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic                      saturated;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;

  int               mismatches;
  int               in_flight;
  int               cycle_cnt = 0;
  bit               gaps_on = 1'b1;
  logic [IDX_W-1:0] cur_grid = GRID_RESET;  // mirror of grid_res for index biasing

  // Per-phase grid sizes: edge cases (1, 16, zero, above max) up front
  int         grid_plan [PHASES] = '{16, 1, 0, 31, 17, 3, 10, 7, 16, 5, 2, 12};
  slice_pat_e pat_plan  [PHASES] = '{PAT_RANDOM, PAT_SMALL, PAT_FLOOR, PAT_CEIL,
                                     PAT_EXTREME, PAT_RANDOM, PAT_SMALL, PAT_FLOOR,
                                     PAT_EXTREME, PAT_CEIL, PAT_RANDOM, PAT_ZERO};

  bezier_warp_grid_point_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .col_index_i (col_index),
    .row_index_i (row_index),
    .done_o      (done),
    .x_coord_o   (x_coord),
    .y_coord_o   (y_coord),
    .saturated_o (saturated),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  bwgp_vertex_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .col_index_i    (col_index),
    .row_index_i    (row_index),
    .done_i         (done),
    .x_coord_i      (x_coord),
    .y_coord_i      (y_coord),
    .saturated_i    (saturated),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatch_cnt_o (mismatches),
    .in_flight_o    (in_flight)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Grid size as the DUT sees it after its own clamping
  function automatic int eff_grid();
    if (cur_grid == 0) begin
      return 1;
    end
    if (cur_grid > MAX_GRID_RES) begin
      return MAX_GRID_RES;
    end
    return cur_grid;
  endfunction

  // Mostly in-range indices, the rest anywhere in the 5-bit field (clamp path)
  function automatic logic [IDX_W-1:0] rand_index();
    if ($urandom_range(0, 99) < 80) begin
      return IDX_W'($urandom_range(0, eff_grid()));
    end
    return IDX_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [COORD_W-1:0] point_slice(slice_pat_e pat);
    unique case (pat)
      PAT_ZERO:   return '0;
      PAT_RANDOM: return COORD_W'($urandom());
      PAT_SMALL:  return COORD_W'($urandom_range(0, 2047)) - 16'd1024;
      PAT_FLOOR:  return 16'h8000 + COORD_W'($urandom_range(0, 3));  // near -2048 px
      PAT_CEIL:   return 16'h7fff - COORD_W'($urandom_range(0, 3));
      default: begin
        unique case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'hffff;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] point_pair(slice_pat_e pat);
    return {point_slice(pat), point_slice(pat), point_slice(pat), point_slice(pat)};
  endfunction

  // Random idle cycles on a channel, start held low meanwhile
  task automatic maybe_idle();
    if (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end
  endtask

  // One config transfer; valid dropped at the next falling edge
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    maybe_idle();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_GRID_RES) begin
      cur_grid = data[IDX_W-1:0];
    end
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // grid_res write with junk in the ignored upper bits
  task automatic set_grid(logic [IDX_W-1:0] g);
    logic [CFG_W-1:0] data;
    data = {$urandom(), $urandom()};
    data[IDX_W-1:0] = g;
    cfg_write(CFG_GRID_RES, data);
  endtask

  task automatic load_points(slice_pat_e pat);
    cfg_write(CFG_CORNER_A, point_pair(pat));
    cfg_write(CFG_CORNER_B, point_pair(pat));
    cfg_write(CFG_HANDLE_A, point_pair(pat));
    cfg_write(CFG_HANDLE_B, point_pair(pat));
    cfg_write(CFG_HANDLE_C, point_pair(pat));
    cfg_write(CFG_HANDLE_D, point_pair(pat));
  endtask

  // Vertex transfer: start stays high into the next item unless a gap drops it
  task automatic send_vertex(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
    maybe_idle();
    @(negedge clk_i);
    start     <= 1'b1;
    col_index <= col;
    row_index <= row;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off until every vertex has come back, then let the pipe empty
  task automatic drain_vertices();
    @(negedge clk_i);
    start <= 1'b0;
    while (in_flight != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset config: grid 10, all points zero; includes clamped indices
    send_vertex(5'd0, 5'd0);
    send_vertex(5'd10, 5'd10);
    send_vertex(5'd31, 5'd31);
    send_vertex(5'd11, 5'd3);
    drain_vertices();

    // Every register, plus a write to the unused index that must be dropped
    set_grid(5'd16);
    load_points(PAT_RANDOM);
    cfg_write(CFG_UNUSED, {$urandom(), $urandom()});
    send_vertex(5'd0, 5'd0);
    send_vertex(5'd16, 5'd16);
    send_vertex(5'd31, 5'd0);
    send_vertex(5'd0, 5'd31);
    send_vertex(5'd17, 5'd17);
    send_vertex(5'd8, 5'd5);
    send_vertex(5'd16, 5'd0);
    send_vertex(5'd0, 5'd16);
    send_vertex(5'd21, 5'd10);
    send_vertex(5'd10, 5'd21);
    drain_vertices();

    // Floor-rounding underflow: everything at the bottom of the range except the
    // top inner handle one LSB up, so the row-0 cubic dips below -32768
    set_grid(5'd3);
    load_points(PAT_ZERO);
    cfg_write(CFG_CORNER_A, {4{16'h8000}});
    cfg_write(CFG_CORNER_B, {4{16'h8000}});
    cfg_write(CFG_HANDLE_A, {16'h8001, 16'h8001, 16'h8000, 16'h8000});
    cfg_write(CFG_HANDLE_B, {4{16'h8000}});
    cfg_write(CFG_HANDLE_C, {4{16'h8000}});
    cfg_write(CFG_HANDLE_D, {4{16'h8000}});
    send_vertex(5'd1, 5'd0);
    send_vertex(5'd2, 5'd0);
    send_vertex(5'd1, 5'd1);
    send_vertex(5'd3, 5'd3);
    drain_vertices();

    // Random phases, each with its own grid size and point shape
    for (int p = 0; p < PHASES; p++) begin
      gaps_on = (p != QUIET_PHASE);
      if (p == PHASES - 1) begin
        set_grid(IDX_W'($urandom_range(0, 31)));
      end else begin
        set_grid(IDX_W'(grid_plan[p]));
      end
      load_points(pat_plan[p]);
      if (p % 4 == 1) begin
        cfg_write(CFG_UNUSED, {$urandom(), $urandom()});
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_vertex(rand_index(), rand_index());
      end
      drain_vertices();
    end

    if (mismatches == 0 && in_flight == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
